### hdl/hrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hrp_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned TdataW  = 88;
  localparam int unsigned QDepth  = 4;

  localparam logic [7:0] CharColon = 8'h3a;

  localparam logic [7:0] RecData   = 8'h00;
  localparam logic [7:0] RecEof    = 8'h01;
  localparam logic [7:0] RecExtLin = 8'h04;
  localparam logic [7:0] RecStart  = 8'h05;

  localparam logic [7:0] ExtLinCount = 8'h02;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoColon  = 3'd1;
  localparam logic [2:0] StHeader   = 3'd2;
  localparam logic [2:0] StLength   = 3'd3;
  localparam logic [2:0] StData     = 3'd4;
  localparam logic [2:0] StCsumMiss = 3'd5;
  localparam logic [2:0] StCsumBad  = 3'd6;
  localparam logic [2:0] StType     = 3'd7;

  typedef enum logic [4:0] {
    PH_COLON  = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_CHECK  = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic        is_status;
    logic [31:0] total_length;
    logic [15:0] upper_address_out;
    logic [15:0] record_address;
    logic [7:0]  record_type;
    logic [2:0]  status_code;
    logic [7:0]  data_byte;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] diff;
    h = '0;
    diff = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      diff = c - 8'h30;
      h.valid = 1'b1;
      h.value = diff[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      diff = c - 8'h57;
      h.valid = 1'b1;
      h.value = diff[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      diff = c - 8'h37;
      h.valid = 1'b1;
      h.value = diff[3:0];
    end
    return h;
  endfunction

endpackage

`default_nettype wire

### hdl/hex_record_parser_top.sv
// Intel HEX record parser: one ASCII character per request on the slave side, tlast on the
// final character of a line. Each character is decoded in the cycle it is accepted, so the
// block takes one character per clock while the output queue has room. Data bytes of type
// 0 records come out as they complete, and every line ends in one status result marked by
// tlast on the master side. Results wait in a four-entry output queue that drains one per
// cycle while the master side is ready; a character is taken while the queue has room for
// two, so a last character that completes a data byte can push both results. Upper address
// and total length persist across lines; everything else is cleared at each end of line.
`timescale 1ns / 1ps
`default_nettype none

module hex_record_parser_top #(
  parameter int unsigned QUEUE_DEPTH = hrp_pkg::QDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [hrp_pkg::CharW-1:0]  s_axis_tdata,   // char_code
  input  wire logic                       s_axis_tlast,   // line_last
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // data_byte, status_code, record_type, record_address, upper_address_out,
  // total_length, zero fill
  output logic [hrp_pkg::TdataW-1:0]      m_axis_tdata,
  output logic                            m_axis_tlast    // is_status
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  hrp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  high_q, high_d;
  logic        pend_q, pend_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  seen_q, seen_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] pupper_q, pupper_d;
  logic [15:0] upper_q, upper_d;
  logic [31:0] len_q, len_d;
  logic [2:0]  err_q, err_d;

  hrp_pkg::result_t   fifo_q [QUEUE_DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    cnt_q;

  hrp_pkg::hex_t      hx;
  logic               s_hs, m_hs;
  logic               emit_data;
  logic [7:0]         byte_v;
  logic [7:0]         sum_chk;
  logic [7:0]         seen_inc;
  logic [32:0]        len_sum;
  logic [2:0]         code_v;
  hrp_pkg::result_t   res0, res1;
  logic [1:0]         n_push;
  hrp_pkg::result_t   head;

  assign s_hs = s_axis_tvalid && s_axis_tready;
  assign m_hs = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q <= CntW'(QUEUE_DEPTH - 2));

  always_comb begin
    phase_d   = phase_q;
    high_d    = high_q;
    pend_d    = pend_q;
    count_d   = count_q;
    seen_d    = seen_q;
    addr_d    = addr_q;
    type_d    = type_q;
    sum_d     = sum_q;
    pupper_d  = pupper_q;
    upper_d   = upper_q;
    len_d     = len_q;
    err_d     = err_q;
    emit_data = 1'b0;
    hx        = hrp_pkg::hex_decode(s_axis_tdata);
    byte_v    = {high_q, hx.value};
    sum_chk   = sum_q + byte_v;
    seen_inc  = seen_q + 8'd1;
    len_sum   = {1'b0, len_q} + {25'd0, count_q};
    code_v    = hrp_pkg::StNoColon;

    unique case (phase_q)
      hrp_pkg::PH_COLON: begin
        if (s_axis_tdata == hrp_pkg::CharColon) begin
          phase_d = hrp_pkg::PH_HEADER;
        end else begin
          err_d   = hrp_pkg::StNoColon;
          phase_d = hrp_pkg::PH_DONE;
        end
      end
      hrp_pkg::PH_HEADER, hrp_pkg::PH_DATA, hrp_pkg::PH_CHECK: begin
        if (!hx.valid) begin
          phase_d = hrp_pkg::PH_DONE;
          if (phase_q == hrp_pkg::PH_HEADER) begin
            err_d = hrp_pkg::StHeader;
          end else if (phase_q == hrp_pkg::PH_DATA) begin
            err_d = hrp_pkg::StData;
          end else begin
            err_d = hrp_pkg::StCsumMiss;
          end
        end else if (!pend_q) begin
          high_d = hx.value;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (phase_q == hrp_pkg::PH_HEADER) begin
            sum_d = sum_chk;
            unique case (seen_q[1:0])
              2'd0: count_d = byte_v;
              2'd1: addr_d  = {byte_v, 8'h00};
              2'd2: addr_d  = {addr_q[15:8], byte_v};
              default: type_d = byte_v;
            endcase
            if (seen_q[1:0] == 2'd3) begin
              seen_d = '0;
              if (byte_v == hrp_pkg::RecData) begin
                phase_d = (count_q == 8'd0) ? hrp_pkg::PH_CHECK : hrp_pkg::PH_DATA;
              end else if (byte_v == hrp_pkg::RecExtLin) begin
                if (count_q != hrp_pkg::ExtLinCount) begin
                  err_d   = hrp_pkg::StLength;
                  phase_d = hrp_pkg::PH_DONE;
                end else begin
                  phase_d = hrp_pkg::PH_DATA;
                end
              end else if (byte_v == hrp_pkg::RecEof || byte_v == hrp_pkg::RecStart) begin
                phase_d = hrp_pkg::PH_DONE;
              end else begin
                err_d   = hrp_pkg::StType;
                phase_d = hrp_pkg::PH_DONE;
              end
            end else begin
              seen_d = seen_inc;
            end
          end else if (phase_q == hrp_pkg::PH_DATA) begin
            sum_d  = sum_chk;
            seen_d = seen_inc;
            if (type_q == hrp_pkg::RecExtLin) begin
              pupper_d = {pupper_q[7:0], byte_v};
            end
            emit_data = (type_q == hrp_pkg::RecData);
            if (seen_inc == count_q) begin
              phase_d = hrp_pkg::PH_CHECK;
              if (type_q == hrp_pkg::RecData) begin
                len_d = len_sum[32] ? 32'hffff_ffff : len_sum[31:0];
              end
            end
          end else begin
            if (sum_chk != 8'd0) begin
              err_d   = hrp_pkg::StCsumBad;
              phase_d = hrp_pkg::PH_DONE;
            end else begin
              if (type_q == hrp_pkg::RecExtLin && pupper_q != 16'd0) begin
                upper_d = pupper_q;
              end
              phase_d = hrp_pkg::PH_DONE;
            end
          end
        end
      end
      hrp_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    unique case (phase_d)
      hrp_pkg::PH_DONE:   code_v = err_d;
      hrp_pkg::PH_HEADER: code_v = hrp_pkg::StHeader;
      hrp_pkg::PH_DATA:   code_v = hrp_pkg::StData;
      hrp_pkg::PH_CHECK:  code_v = hrp_pkg::StCsumMiss;
      default:            code_v = hrp_pkg::StNoColon;
    endcase

    res0.is_status         = 1'b0;
    res0.total_length      = len_d;
    res0.upper_address_out = upper_d;
    res0.record_address    = addr_d;
    res0.record_type       = type_d;
    res0.status_code       = hrp_pkg::StOk;
    res0.data_byte         = byte_v;

    res1                   = res0;
    res1.is_status         = 1'b1;
    res1.status_code       = code_v;
    res1.data_byte         = 8'd0;

    n_push = 2'd0;
    if (s_hs) begin
      n_push = {1'b0, emit_data} + {1'b0, s_axis_tlast};
      if (!emit_data) begin
        res0 = res1;
      end
      if (s_axis_tlast) begin
        phase_d  = hrp_pkg::PH_COLON;
        high_d   = '0;
        pend_d   = 1'b0;
        count_d  = '0;
        seen_d   = '0;
        addr_d   = '0;
        type_d   = '0;
        sum_d    = '0;
        pupper_d = '0;
        err_d    = hrp_pkg::StOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= hrp_pkg::PH_COLON;
      high_q   <= '0;
      pend_q   <= 1'b0;
      count_q  <= '0;
      seen_q   <= '0;
      addr_q   <= '0;
      type_q   <= '0;
      sum_q    <= '0;
      pupper_q <= '0;
      upper_q  <= '0;
      len_q    <= '0;
      err_q    <= hrp_pkg::StOk;
    end else if (s_hs) begin
      phase_q  <= phase_d;
      high_q   <= high_d;
      pend_q   <= pend_d;
      count_q  <= count_d;
      seen_q   <= seen_d;
      addr_q   <= addr_d;
      type_q   <= type_d;
      sum_q    <= sum_d;
      pupper_q <= pupper_d;
      upper_q  <= upper_d;
      len_q    <= len_d;
      err_q    <= err_d;
    end
  end

  // output queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      if (m_hs) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(n_push) - CntW'(m_hs);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tlast  = head.is_status;
  assign m_axis_tdata  = {5'd0, head.total_length, head.upper_address_out,
                          head.record_address, head.record_type, head.status_code,
                          head.data_byte};

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QUEUE_DEPTH))
    else $error("output queue overfilled");

  a_line_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_hs && s_axis_tlast) |=> (phase_q == hrp_pkg::PH_COLON && !pend_q))
    else $error("line state not cleared at end of line");

  a_nibble_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (phase_q != hrp_pkg::PH_COLON))
    else $error("half byte held outside a record line");

  a_header_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == hrp_pkg::PH_HEADER) |-> (seen_q <= 8'd3))
    else $error("header byte index out of range");

  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_hs && s_axis_tlast) |=> (cnt_q != '0))
    else $error("end of line left no status result");

endmodule

`default_nettype wire
